@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared constants, codes and types for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH_DEF   = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 6;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_APPLY
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                      load;
    logic                      ins;
    logic                      del;
    logic signed [VALUE_W-1:0] value;
  } ctrl_t;

endpackage

`default_nettype wire

@@ design/spq_in_if.sv @@
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one queue command and its value.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_in_if;
  logic                               valid;
  logic                               ready;
  logic                               command;
  logic signed [spq_pkg::VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

`default_nettype wire

@@ design/spq_out_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying status, count and head value.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [spq_pkg::STATUS_W-1:0]         status;
  logic [spq_pkg::COUNT_OUT_W-1:0]      count;
  logic signed [spq_pkg::VALUE_W-1:0]   head_value;

  modport source (output valid, output status, output count, output head_value,
                  input ready);
  modport sink   (input valid, input status, input count, input head_value,
                  output ready);
endinterface

`default_nettype wire

@@ design/spq_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted queue cell
// Holds one entry, compares it with the broadcast value and shifts with
// its neighbors on insert or delete.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire spq_pkg::ctrl_t                     ctrl,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] left_entry,
  input  wire logic                               left_valid,
  input  wire logic                               left_ge,
  input  wire logic signed [spq_pkg::VALUE_W-1:0] right_entry,
  input  wire logic                               right_valid,
  output logic signed [spq_pkg::VALUE_W-1:0]      entry,
  output logic                                    valid,
  output logic                                    ge,
  output logic                                    eq
);

  // ge: the value belongs at or before this cell (empty cells always qualify).
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ge <= !valid || (ctrl.value >= entry);
      eq <= valid && (ctrl.value == entry);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.ins) begin
      if (left_ge) begin
        valid <= left_valid;
      end else if (ge) begin
        valid <= 1'b1;
      end
    end else if (ctrl.del && ge) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_ge) begin
        entry <= left_entry;
      end else if (ge) begin
        entry <= ctrl.value;
      end
    end else if (ctrl.del && ge) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire

@@ design/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue
// Keeps up to DEPTH signed values in descending order in a row of cells.
// ----------------------------------------------------------------------------
//   channel  dir  payload                        handshake
//   req      in   command, value                 valid/ready
//   rsp      out  status, count, head_value      valid/ready
//
// Each request goes through three steps: accept, compare in every cell, then shift.
// The compare and the shift are split so the first-match search can be an
// OR over the registered cell flags. The result sits in an output register;
// the next request is taken while it waits. If the result register is still
// full at the shift cycle, the shift waits. Reset empties the queue at once.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  spq_in_if.sink     req,
  spq_out_if.source  rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VW = spq_pkg::VALUE_W;

  spq_pkg::state_t state, state_next;
  spq_pkg::ctrl_t  ctrl;

  logic                 cmd_q;
  logic signed [VW-1:0] value_q;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;

  logic signed [VW-1:0] ent [DEPTH];
  logic [DEPTH-1:0]     vld;
  logic [DEPTH-1:0]     ge;
  logic [DEPTH-1:0]     eq;
  logic [DEPTH-1:0]     first;

  logic                 full;
  logic                 empty;
  logic                 found;
  logic                 is_ins;
  logic                 out_free;
  logic                 do_apply;
  spq_pkg::status_t     status_calc;
  logic signed [VW-1:0] head_calc;
  logic [CW+spq_pkg::COUNT_OUT_W-1:0] count_wide;

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_first
        spq_cell u_cell (
          .clk, .rst, .ctrl,
          .left_entry  ('0),
          .left_valid  (1'b0),
          .left_ge     (1'b0),
          .right_entry (ent[k+1]),
          .right_valid (vld[k+1]),
          .entry       (ent[k]),
          .valid       (vld[k]),
          .ge          (ge[k]),
          .eq          (eq[k])
        );
        assign first[k] = ge[k];
      end else if (k == DEPTH - 1) begin : g_last
        spq_cell u_cell (
          .clk, .rst, .ctrl,
          .left_entry  (ent[k-1]),
          .left_valid  (vld[k-1]),
          .left_ge     (ge[k-1]),
          .right_entry ('0),
          .right_valid (1'b0),
          .entry       (ent[k]),
          .valid       (vld[k]),
          .ge          (ge[k]),
          .eq          (eq[k])
        );
        assign first[k] = ge[k] && !ge[k-1];
      end else begin : g_mid
        spq_cell u_cell (
          .clk, .rst, .ctrl,
          .left_entry  (ent[k-1]),
          .left_valid  (vld[k-1]),
          .left_ge     (ge[k-1]),
          .right_entry (ent[k+1]),
          .right_valid (vld[k+1]),
          .entry       (ent[k]),
          .valid       (vld[k]),
          .ge          (ge[k]),
          .eq          (eq[k])
        );
        assign first[k] = ge[k] && !ge[k-1];
      end
    end
  endgenerate

  // Equal values sit together, so the first match can only be at the cell
  // where the value stops being smaller than the stored entries.
  assign found    = |(first & eq);
  assign full     = vld[DEPTH-1];
  assign empty    = !vld[0];
  assign is_ins   = (cmd_q == spq_pkg::CMD_INSERT);
  assign out_free = !rsp.valid || rsp.ready;
  assign do_apply = (state == spq_pkg::S_APPLY) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      spq_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = spq_pkg::S_CALC;
        end
      end
      spq_pkg::S_CALC: begin
        state_next = spq_pkg::S_APPLY;
      end
      spq_pkg::S_APPLY: begin
        if (out_free) begin
          state_next = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    req.ready  = (state == spq_pkg::S_IDLE);
    ctrl.load  = (state == spq_pkg::S_CALC);
    ctrl.ins   = do_apply && is_ins && !full;
    ctrl.del   = do_apply && !is_ins && !empty && found;
    ctrl.value = value_q;
  end

  always_comb begin
    status_calc = spq_pkg::ST_OK;
    count_next  = count;
    head_calc   = vld[0] ? ent[0] : '0;
    if (is_ins) begin
      if (full) begin
        status_calc = spq_pkg::ST_FULL;
      end else begin
        count_next = count + 1'b1;
        head_calc  = ge[0] ? value_q : ent[0];
      end
    end else if (empty) begin
      status_calc = spq_pkg::ST_EMPTY;
    end else if (!found) begin
      status_calc = spq_pkg::ST_NOTFOUND;
    end else begin
      count_next = count - 1'b1;
      if (ge[0]) begin
        head_calc = vld[1] ? ent[1] : '0;
      end
    end
  end

  assign count_wide = {{spq_pkg::COUNT_OUT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spq_pkg::S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_apply) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q   <= req.command;
      value_q <= req.value;
    end
    if (do_apply) begin
      rsp.status     <= status_calc;
      rsp.count      <= count_wide[spq_pkg::COUNT_OUT_W-1:0];
      rsp.head_value <= head_calc;
    end
  end

endmodule

`default_nettype wire

@@ bench/spq_result_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue result checker
// Watches the request and result channels, keeps a shadow copy of the sorted
// queue, and compares every result with the expected status, count and head.
// ----------------------------------------------------------------------------
module spq_result_checker (
  input  logic clk,
  input  logic rst,
  spq_in_if    req,
  spq_out_if   rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;
  localparam int COUNT_W      = spq_pkg::COUNT_OUT_W;

  typedef struct {
    spq_pkg::status_t                   status;
    logic [spq_pkg::COUNT_OUT_W-1:0]    count;
    logic signed [spq_pkg::VALUE_W-1:0] head;
  } queue_result_t;

  // Shadow queue, head at index 0, kept in descending order.
  logic signed [spq_pkg::VALUE_W-1:0] queue_contents[$];
  queue_result_t                      expected_results[$];
  int                                 mismatches = 0;

  function automatic queue_result_t apply_request(
    logic command, logic signed [spq_pkg::VALUE_W-1:0] val);
    queue_result_t r;
    int            slot;
    r.status = spq_pkg::ST_OK;
    slot = -1;
    if (command == spq_pkg::CMD_INSERT) begin
      if (queue_contents.size() >= spq_pkg::DEPTH_DEF) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // A new value goes ahead of the first entry it equals or exceeds.
        slot = queue_contents.size();
        for (int k = queue_contents.size() - 1; k >= 0; k--) begin
          if (val >= queue_contents[k]) slot = k;
        end
        if (slot == queue_contents.size()) queue_contents.push_back(val);
        else queue_contents.insert(slot, val);
      end
    end else if (queue_contents.size() == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      for (int k = queue_contents.size() - 1; k >= 0; k--) begin
        if (queue_contents[k] == val) slot = k;
      end
      if (slot < 0) r.status = spq_pkg::ST_NOTFOUND;
      else queue_contents.delete(slot);
    end
    r.count = COUNT_W'(queue_contents.size());
    r.head  = (queue_contents.size() > 0) ? queue_contents[0] : '0;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  task automatic check_result();
    queue_result_t want;
    if (expected_results.size() == 0) begin
      note_failure($sformatf("result with no request waiting: status %0d count %0d head %0d",
                             rsp.status, rsp.count, rsp.head_value));
      return;
    end
    want = expected_results.pop_front();
    if (rsp.status !== want.status || rsp.count !== want.count ||
        rsp.head_value !== want.head) begin
      note_failure($sformatf(
        "expected status %s count %0d head %0d, got status %0d count %0d head %0d",
        want.status.name(), want.count, want.head,
        rsp.status, rsp.count, rsp.head_value));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      queue_contents.delete();
      expected_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) check_result();
      if (req.valid && req.ready) begin
        expected_results.push_back(apply_request(req.command, req.value));
      end
    end
    pending    <= expected_results.size();
    fail_count <= mismatches;
  end

endmodule

@@ bench/sorted_priority_queue_tb.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives directed and random insert and delete requests with varying idle and
// stall patterns, and lets the result checker compare every response.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 3;
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 250;
  localparam int HOLD_REQUESTS = 40;
  localparam int DRAIN_CYCLES  = 12;
  localparam int SEGMENT_ITEMS = 150;
  localparam int POOL_SIZE     = 12;

  localparam logic signed [spq_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fffffff;
  localparam logic signed [spq_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh80000000;

  logic clk;
  logic rst;
  logic hold_results = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   fail_count;
  int   pending;
  logic signed [spq_pkg::VALUE_W-1:0] value_pool[POOL_SIZE];

  spq_in_if  req ();
  spq_out_if rsp ();

  sorted_priority_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  spq_result_checker result_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Result side: random stalls, or one long hold when requested.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [spq_pkg::VALUE_W-1:0] extreme_value();
    case ($urandom_range(3))
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  // A small pool of values per phase, so deletes often find a match and
  // duplicates pile up.
  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(2))
        0: value_pool[i] = $signed($urandom_range(20)) - 10;
        1: value_pool[i] = $urandom;
        default: value_pool[i] = extreme_value();
      endcase
    end
  endtask

  function automatic logic signed [spq_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return $urandom;
      1: return extreme_value();
      default: return value_pool[$urandom_range(POOL_SIZE - 1)];
    endcase
  endfunction

  // Called and returns just after a rising edge; valid stays high after the
  // request is taken so back-to-back requests need no gap.
  task automatic send_req(spq_pkg::cmd_t cmd, logic signed [spq_pkg::VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.command <= cmd;
    req.value   <= val;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_segment(int insert_pct);
    spq_pkg::cmd_t cmd;
    for (int i = 0; i < SEGMENT_ITEMS; i++) begin
      cmd = ($urandom_range(99) < insert_pct) ? spq_pkg::CMD_INSERT : spq_pkg::CMD_DELETE;
      send_req(cmd, pick_value());
    end
    wait_drained();
  endtask

  // Results are held off while requests keep coming, so the queue backs up
  // and the request side stalls.
  task automatic hold_off_results();
    send_idle_pct = 0;
    hold_results <= 1'b1;
    for (int i = 0; i < HOLD_REQUESTS; i++) begin
      send_req($urandom_range(99) < 70 ? spq_pkg::CMD_INSERT : spq_pkg::CMD_DELETE,
               pick_value());
    end
    wait_drained();
  endtask

  initial begin
    rst         = 1'b1;
    req.valid   = 1'b0;
    req.command = spq_pkg::CMD_INSERT;
    req.value   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty delete, extremes, duplicates, misses, removal of the
    // head and of the last entry, then back down to empty.
    send_req(spq_pkg::CMD_DELETE, 0);
    send_req(spq_pkg::CMD_INSERT, 0);
    send_req(spq_pkg::CMD_INSERT, VALUE_MAX);
    send_req(spq_pkg::CMD_INSERT, VALUE_MIN);
    send_req(spq_pkg::CMD_INSERT, -1);
    send_req(spq_pkg::CMD_INSERT, 5);
    send_req(spq_pkg::CMD_INSERT, 5);
    send_req(spq_pkg::CMD_INSERT, VALUE_MAX);
    send_req(spq_pkg::CMD_DELETE, 5);
    send_req(spq_pkg::CMD_DELETE, 7);
    send_req(spq_pkg::CMD_DELETE, VALUE_MAX);
    send_req(spq_pkg::CMD_DELETE, VALUE_MIN);
    send_req(spq_pkg::CMD_INSERT, 1);
    send_req(spq_pkg::CMD_DELETE, 5);
    send_req(spq_pkg::CMD_DELETE, -1);
    send_req(spq_pkg::CMD_DELETE, 0);
    send_req(spq_pkg::CMD_DELETE, 1);
    send_req(spq_pkg::CMD_DELETE, VALUE_MAX);
    send_req(spq_pkg::CMD_DELETE, VALUE_MAX);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      refresh_pool();
      if (phase == 2) begin
        hold_off_results();
        send_idle_pct = 0;
      end
      // Fill past full, churn, then drain past empty.
      run_segment(80);
      run_segment(55);
      run_segment(25);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sorted_priority_queue.f @@
design/spq_pkg.sv
design/spq_in_if.sv
design/spq_out_if.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
bench/spq_result_checker.sv
bench/sorted_priority_queue_tb.sv
